[design/dto_pkg.sv]
package dto_pkg;

    localparam int DIGITS    = 10;
    localparam int OTP_LEN   = 6;
    localparam int KEY_W     = 4 * DIGITS;
    localparam int CODE_W    = 4 * OTP_LEN;
    localparam int STAGES    = 6;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [6:0]        year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [CODE_W-1:0] entered_code;
    } item_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] otp_code;
        logic              code_match;
        logic              key_bad;
    } result_beat_t;

    // sum of two digits, reduced once; exact for sums below 20
    function automatic digit_t mod10_small(input logic [4:0] s);
        digit_t r;
        if (s >= 5'd10)
        begin
            r = 4'(s - 5'd10);
        end
        else
        begin
            r = s[3:0];
        end
        return r;
    endfunction

    // {tens mod 10, ones} of a value below 128; reciprocal 205/2048 for /10
    function automatic logic [7:0] split_pair(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        digit_t      tens;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        r    = v - 7'(q) * 7'd10;
        if (q >= 4'd10)
        begin
            tens = 4'(q - 4'd10);
        end
        else
        begin
            tens = q;
        end
        return {tens, r[3:0]};
    endfunction

endpackage

[design/dto_stream_if.sv]
interface dto_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/decimal_time_otp_generator.sv]
// An accepted item beat moves through the stage registers in order to its result beat, one stage per register.
// Throughput: one item per cycle; each stage holds while the next one is full and stalled,
// so the result register can wait on the sink while new items keep entering.
// Reset (rst_n, asynchronous, active low) clears the key to zero and empties the pipeline.
// A key write takes effect for an item accepted on the same edge.
module decimal_time_otp_generator
    import dto_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_we,
    input  logic [KEY_W-1:0] key_wdata,
    dto_stream_if.sink       item,
    dto_stream_if.source     result
);

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_eff;
    logic [STAGES:1]   stage_valid_reg;
    logic [STAGES:1]   adv;

    // stage 1: key digits, time digits, key-added digits, first-use flags
    digit_t            s1_k_next   [DIGITS];
    digit_t            s1_x_next   [DIGITS];
    digit_t            t           [DIGITS];
    logic [DIGITS-1:0] s1_f_next;
    logic [DIGITS-1:0] s1_used_next;
    logic              s1_bad_next;
    logic [7:0]        tp          [5];

    digit_t            s1_k_reg    [DIGITS];
    digit_t            s1_x_reg    [DIGITS];
    logic [DIGITS-1:0] s1_f_reg;
    logic [DIGITS-1:0] s1_used_reg;
    logic              s1_bad_reg;
    logic [CODE_W-1:0] s1_entered_reg;

    // stage 2: substitution table
    digit_t            s2_perm_next [DIGITS];
    digit_t            pos          [DIGITS];
    digit_t            rank         [DIGITS];
    digit_t            n_first;

    digit_t            s2_perm_reg  [DIGITS];
    digit_t            s2_x_reg     [DIGITS];
    logic              s2_bad_reg;
    logic [CODE_W-1:0] s2_entered_reg;

    // stage 3: substituted digits
    digit_t            s3_c_next    [DIGITS];
    digit_t            s3_c_reg     [DIGITS];
    logic              s3_bad_reg;
    logic [CODE_W-1:0] s3_entered_reg;

    // stages 4 and 5: diffusion chain, first and second half
    digit_t            s4_d_next    [DIGITS];
    digit_t            s4_d_reg     [DIGITS];
    logic              s4_bad_reg;
    logic [CODE_W-1:0] s4_entered_reg;

    digit_t            s5_d_next    [DIGITS];
    digit_t            s5_d_reg     [DIGITS];
    logic              s5_bad_reg;
    logic [CODE_W-1:0] s5_entered_reg;

    // stage 6: fold and compare
    digit_t            o            [OTP_LEN];
    logic [5:0]        o_sum;
    logic [7:0]        o_pair;
    logic [CODE_W-1:0] code;
    result_beat_t      s6_beat_next;
    result_beat_t      s6_beat_reg;

    assign key_eff = key_we ? key_wdata : key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_we)
        begin
            key_reg <= key_wdata;
        end
    end

    // ---------------- handshake ----------------
    always_comb
    begin
        adv[STAGES] = !stage_valid_reg[STAGES] || result.ready;
        for (int s = STAGES - 1; s >= 1; s--)
        begin
            adv[s] = !stage_valid_reg[s] || adv[s+1];
        end
    end

    assign item.ready   = adv[1];
    assign result.valid = stage_valid_reg[STAGES];
    assign result.data  = s6_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                stage_valid_reg[1] <= item.valid;
            end
            for (int s = 2; s <= STAGES; s++)
            begin
                if (adv[s])
                begin
                    stage_valid_reg[s] <= stage_valid_reg[s-1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        s1_bad_next = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            s1_k_next[i] = key_eff[4*(DIGITS-1-i) +: 4];
            if (s1_k_next[i] > 4'd9)
            begin
                s1_bad_next = 1'b1;
            end
        end

        tp[0] = split_pair(item.data.year);
        tp[1] = split_pair({3'b000, item.data.month});
        tp[2] = split_pair({2'b00, item.data.day});
        tp[3] = split_pair({2'b00, item.data.hour});
        tp[4] = split_pair({1'b0, item.data.minute});
        for (int p = 0; p < 5; p++)
        begin
            t[2*p]   = tp[p][7:4];
            t[2*p+1] = tp[p][3:0];
        end

        for (int i = 0; i < DIGITS; i++)
        begin
            s1_x_next[i] = mod10_small(5'(s1_k_next[i]) + 5'(t[i]));
        end

        // a key digit is placed in the table only where it first appears
        for (int i = 0; i < DIGITS; i++)
        begin
            s1_f_next[i] = 1'b1;
            for (int j = 0; j < DIGITS; j++)
            begin
                if (j < i && s1_k_next[j] == s1_k_next[i])
                begin
                    s1_f_next[i] = 1'b0;
                end
            end
        end

        for (int m = 0; m < DIGITS; m++)
        begin
            s1_used_next[m] = 1'b0;
            for (int i = 0; i < DIGITS; i++)
            begin
                if (s1_k_next[i] == 4'(m))
                begin
                    s1_used_next[m] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_k_reg       <= s1_k_next;
            s1_x_reg       <= s1_x_next;
            s1_f_reg       <= s1_f_next;
            s1_used_reg    <= s1_used_next;
            s1_bad_reg     <= s1_bad_next;
            s1_entered_reg <= item.data.entered_code;
        end
    end

    // ---------------- stage 2 ----------------
    // table slot of a first-use key digit = first-use digits ahead of it;
    // a missing digit goes after all of them, in ascending order
    always_comb
    begin
        n_first = 4'($countones(s1_f_reg));
        for (int i = 0; i < DIGITS; i++)
        begin
            pos[i]  = 4'($countones(s1_f_reg & ((DIGITS'(1) << i) - DIGITS'(1))));
            rank[i] = 4'($countones(~s1_used_reg & ((DIGITS'(1) << i) - DIGITS'(1))));
        end
        for (int j = 0; j < DIGITS; j++)
        begin
            s2_perm_next[j] = '0;
            for (int i = 0; i < DIGITS; i++)
            begin
                if (s1_f_reg[i] && pos[i] == 4'(j))
                begin
                    s2_perm_next[j] = s2_perm_next[j] | s1_k_reg[i];
                end
                if (!s1_used_reg[i] && 4'(n_first + rank[i]) == 4'(j))
                begin
                    s2_perm_next[j] = s2_perm_next[j] | 4'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_perm_reg    <= s2_perm_next;
            s2_x_reg       <= s1_x_reg;
            s2_bad_reg     <= s1_bad_reg;
            s2_entered_reg <= s1_entered_reg;
        end
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            s3_c_next[i] = '0;
            for (int j = 0; j < DIGITS; j++)
            begin
                if (s2_x_reg[i] == 4'(j))
                begin
                    s3_c_next[i] = s2_perm_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_c_reg       <= s3_c_next;
            s3_bad_reg     <= s2_bad_reg;
            s3_entered_reg <= s2_entered_reg;
        end
    end

    // ---------------- stage 4 ----------------
    // chain seeded by the last digit; first five links here
    always_comb
    begin
        s4_d_next    = s3_c_reg;
        s4_d_next[0] = mod10_small(5'(s3_c_reg[0]) + 5'(s3_c_reg[DIGITS-1]));
        for (int i = 1; i < DIGITS / 2; i++)
        begin
            s4_d_next[i] = mod10_small(5'(s3_c_reg[i]) + 5'(s4_d_next[i-1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_d_reg       <= s4_d_next;
            s4_bad_reg     <= s3_bad_reg;
            s4_entered_reg <= s3_entered_reg;
        end
    end

    // ---------------- stage 5 ----------------
    always_comb
    begin
        s5_d_next = s4_d_reg;
        for (int i = DIGITS / 2; i < DIGITS; i++)
        begin
            s5_d_next[i] = mod10_small(5'(s4_d_reg[i]) + 5'(s5_d_next[i-1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_d_reg       <= s5_d_next;
            s5_bad_reg     <= s4_bad_reg;
            s5_entered_reg <= s4_entered_reg;
        end
    end

    // ---------------- stage 6 ----------------
    // sum of all ten digits mod 10 equals sum of the five folded digits mod 10
    always_comb
    begin
        o_sum = '0;
        for (int i = 0; i < OTP_LEN - 1; i++)
        begin
            o[i]  = mod10_small(5'(s5_d_reg[i]) + 5'(s5_d_reg[i + DIGITS / 2]));
            o_sum = o_sum + 6'(o[i]);
        end
        o_pair       = split_pair({1'b0, o_sum});
        o[OTP_LEN-1] = o_pair[3:0];

        for (int i = 0; i < OTP_LEN; i++)
        begin
            code[4*(OTP_LEN-1-i) +: 4] = o[i];
        end

        if (s5_bad_reg)
        begin
            s6_beat_next.otp_code   = '0;
            s6_beat_next.code_match = 1'b0;
            s6_beat_next.key_bad    = 1'b1;
        end
        else
        begin
            s6_beat_next.otp_code   = code;
            s6_beat_next.code_match = (code == s5_entered_reg);
            s6_beat_next.key_bad    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_beat_reg <= s6_beat_next;
        end
    end

    // ---------------- checks ----------------
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> stage_valid_reg[1])
        else $error("accepted beat did not reach the first stage");

    a_bad_key_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.key_bad
            |-> !result.data.code_match && result.data.otp_code == '0)
        else $error("bad key result carries a code or a match");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(s6_beat_reg))
        else $error("stalled result beat changed");

endmodule

[verif/decimal_time_otp_generator_test.sv]
module decimal_time_otp_generator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dto_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             key_we;
    logic [KEY_W-1:0] key_wdata;

    dto_stream_if #(.payload_t(item_beat_t))   item_if ();
    dto_stream_if #(.payload_t(result_beat_t)) result_if ();

    decimal_time_otp_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_we    (key_we),
        .key_wdata (key_wdata),
        .item      (item_if),
        .result    (result_if)
    );

    result_beat_t     otp_pending [$];
    logic [KEY_W-1:0] key_now = '0;    // key as the stimulus side last wrote it
    logic [KEY_W-1:0] key_shadow = '0; // key as seen on the port by the monitor
    int               sender_idle_pct = 0;
    int               sink_stall_pct = 0;
    int               items_sent = 0;
    int               results_seen = 0;
    int               error_count = 0;
    int               match_count = 0;
    int               bad_key_count = 0;
    int               key_writes = 0;
    int               cycle_count = 0;

    always #10 clk = ~clk;

    // Predicted result beat for one calendar minute under a given key.
    function automatic result_beat_t otp_for_minute(logic [KEY_W-1:0] key, item_beat_t it);
        digit_t            key_dig [DIGITS];
        digit_t            time_dig [DIGITS];
        digit_t            subst [DIGITS];
        digit_t            mixed [DIGITS];
        bit                taken [DIGITS];
        int                fields [5];
        int                filled;
        int                acc;
        int                total;
        bit                bad;
        logic [CODE_W-1:0] code;
        result_beat_t      res;
        bad = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            key_dig[i] = key[4*(DIGITS-1-i) +: 4];
            if (key_dig[i] > 4'd9)
            begin
                bad = 1'b1;
            end
        end
        res.otp_code   = '0;
        res.code_match = 1'b0;
        res.key_bad    = bad;
        if (bad)
        begin
            return res;
        end
        fields[0] = int'(it.year);
        fields[1] = int'(it.month);
        fields[2] = int'(it.day);
        fields[3] = int'(it.hour);
        fields[4] = int'(it.minute);
        // out-of-range values are split as they stand, tens taken mod 10
        for (int j = 0; j < 5; j++)
        begin
            time_dig[2*j]   = digit_t'((fields[j] / 10) % 10);
            time_dig[2*j+1] = digit_t'(fields[j] % 10);
        end
        // substitution: distinct key digits in order, then the missing ones ascending
        for (int d = 0; d < DIGITS; d++)
        begin
            taken[d] = 1'b0;
        end
        filled = 0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (!taken[key_dig[i]])
            begin
                taken[key_dig[i]] = 1'b1;
                subst[filled] = key_dig[i];
                filled++;
            end
        end
        for (int d = 0; d < DIGITS; d++)
        begin
            if (!taken[d])
            begin
                subst[filled] = digit_t'(d);
                filled++;
            end
        end
        for (int i = 0; i < DIGITS; i++)
        begin
            mixed[i] = subst[(int'(time_dig[i]) + int'(key_dig[i])) % 10];
        end
        acc = int'(mixed[DIGITS-1]);
        for (int i = 0; i < DIGITS; i++)
        begin
            mixed[i] = digit_t'((int'(mixed[i]) + acc) % 10);
            acc = int'(mixed[i]);
        end
        code  = '0;
        total = 0;
        for (int i = 0; i < 5; i++)
        begin
            code = {code[CODE_W-5:0], digit_t'((int'(mixed[i]) + int'(mixed[i+5])) % 10)};
        end
        for (int i = 0; i < DIGITS; i++)
        begin
            total += int'(mixed[i]);
        end
        code = {code[CODE_W-5:0], digit_t'(total % 10)};
        res.otp_code   = code;
        res.code_match = (code == it.entered_code);
        return res;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void check_field(string fname, logic [CODE_W-1:0] want,
                                        logic [CODE_W-1:0] got);
        if (want !== got)
        begin
            note_error($sformatf("%s expected %h, got %h", fname, want, got));
        end
    endfunction

    function automatic item_beat_t make_item(int y, int mo, int d, int h, int mi,
                                             logic [CODE_W-1:0] code);
        item_beat_t it;
        it.year         = 7'(y);
        it.month        = 4'(mo);
        it.day          = 5'(d);
        it.hour         = 5'(h);
        it.minute       = 6'(mi);
        it.entered_code = code;
        return it;
    endfunction

    // the code the block should compute for this minute under the current key
    function automatic logic [CODE_W-1:0] code_for(item_beat_t it);
        result_beat_t res;
        res = otp_for_minute(key_now, it);
        return res.otp_code;
    endfunction

    // same code with one digit changed to another valid digit
    function automatic logic [CODE_W-1:0] near_miss(logic [CODE_W-1:0] code);
        int pos;
        pos = $urandom_range(OTP_LEN - 1);
        code[4*pos +: 4] = digit_t'((int'(code[4*pos +: 4]) + $urandom_range(1, 9)) % 10);
        return code;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        int               base;
        int               span;
        k    = '0;
        base = $urandom_range(9);
        span = $urandom_range(9);  // narrow spans give many repeated digits
        for (int i = 0; i < DIGITS; i++)
        begin
            k = {k[KEY_W-5:0], digit_t'((base + $urandom_range(span)) % 10)};
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] broken_key();
        logic [KEY_W-1:0] k;
        int               pos;
        k   = random_key();
        pos = $urandom_range(DIGITS - 1);
        k[4*pos +: 4] = 4'($urandom_range(10, 15));
        return k;
    endfunction

    function automatic item_beat_t random_item();
        item_beat_t        it;
        logic [CODE_W-1:0] code;
        int                pick;
        if ($urandom_range(9) == 0)
        begin
            it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, '0);
        end
        else
        begin
            it = make_item($urandom_range(99), $urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(23), $urandom_range(59), '0);
        end
        code = code_for(it);
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            it.entered_code = code;
        end
        else if (pick < 6)
        begin
            it.entered_code = near_miss(code);
        end
        else
        begin
            it.entered_code = CODE_W'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(item_beat_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
        items_sent++;
    endtask

    task automatic drain_items();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen < items_sent);
    endtask

    task automatic write_key(logic [KEY_W-1:0] k);
        drain_items();
        key_we    <= 1'b1;
        key_wdata <= k;
        key_now    = k;
        @(posedge clk);
        key_we <= 1'b0;
        key_writes++;
    endtask

    task automatic test_reset_key();
        send_item(make_item(0, 0, 0, 0, 0, '0));
        send_item(make_item(99, 12, 31, 23, 59, 24'h999999));
        send_item(make_item(127, 15, 31, 31, 63, 24'hFFFFFF));
        send_item(make_item(0, 1, 1, 0, 0, 24'h000000));
    endtask

    task automatic test_code_match();
        item_beat_t        it;
        logic [CODE_W-1:0] code;
        write_key(40'h0123456789);
        it   = make_item(24, 6, 15, 13, 37, '0);
        code = code_for(it);
        it.entered_code = code;
        send_item(it);
        it.entered_code = {code[CODE_W-1:4], digit_t'((int'(code[3:0]) + 1) % 10)};
        send_item(it);
        // a nibble above 9 can never equal a computed digit
        it.entered_code = {4'hA, code[CODE_W-5:0]};
        send_item(it);
        it = make_item(100, 13, 0, 24, 60, '0);
        it.entered_code = code_for(it);
        send_item(it);
    endtask

    task automatic test_key_extremes();
        item_beat_t it;
        write_key(40'h9999999999);
        it = make_item(99, 12, 31, 23, 59, '0);
        it.entered_code = code_for(it);
        send_item(it);
        send_item(make_item(0, 1, 1, 0, 0, 24'h123456));
        write_key(40'h9876543210);
        it = make_item(7, 3, 9, 5, 1, '0);
        it.entered_code = code_for(it);
        send_item(it);
        write_key(40'h1122334455);
        it = make_item(50, 8, 16, 12, 30, '0);
        it.entered_code = code_for(it);
        send_item(it);
        send_item(make_item(64, 8, 16, 16, 32, 24'h000000));
    endtask

    task automatic test_bad_key();
        write_key(40'hFFFFFFFFFF);
        // forced code is zero, an entered zero must still not match
        send_item(make_item(99, 12, 31, 23, 59, 24'h000000));
        send_item(make_item(0, 1, 1, 0, 0, 24'hFFFFFF));
        write_key(40'h012345678A);
        send_item(make_item(12, 4, 20, 8, 45, 24'h000000));
        write_key(40'hA000000000);
        send_item(make_item(33, 11, 2, 19, 7, 24'h550055));
    endtask

    task automatic test_random_traffic();
        int idle_pick [4];
        int stall_pick [4];
        idle_pick  = '{0, 66, 0, 29};
        stall_pick = '{0, 0, 66, 29};
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_pick[p];
            sink_stall_pct  = stall_pick[p];
            for (int c = 0; c < 3; c++)
            begin
                if (p == 1 && c == 2)
                begin
                    write_key(broken_key());
                end
                else
                begin
                    write_key(random_key());
                end
                for (int n = 0; n < 100; n++)
                begin
                    // hold off mid-stream until the pipeline has emptied
                    if (n == 50 && c == 0)
                    begin
                        drain_items();
                    end
                    send_item(random_item());
                end
            end
        end
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
    endtask

    always @(posedge clk)
    begin
        result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        result_beat_t want;
        if (rst_n)
        begin
            // a key written on the same edge already applies to the accepted beat
            if (key_we)
            begin
                key_shadow = key_wdata;
            end
            if (item_if.valid && item_if.ready)
            begin
                otp_pending.push_back(otp_for_minute(key_shadow, item_if.data));
            end
            if (result_if.valid && result_if.ready)
            begin
                results_seen++;
                if (otp_pending.size() == 0)
                begin
                    note_error($sformatf("result beat %h with nothing pending",
                                         result_if.data));
                end
                else
                begin
                    want = otp_pending.pop_front();
                    check_field("otp_code", want.otp_code, result_if.data.otp_code);
                    check_field("code_match", CODE_W'(want.code_match),
                                CODE_W'(result_if.data.code_match));
                    check_field("key_bad", CODE_W'(want.key_bad),
                                CODE_W'(result_if.data.key_bad));
                    if (want.code_match)
                    begin
                        match_count++;
                    end
                    if (want.key_bad)
                    begin
                        bad_key_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[decimal_time_otp_generator] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        key_we          = 1'b0;
        key_wdata       = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key();
        test_code_match();
        test_key_extremes();
        test_bad_key();
        test_random_traffic();
        drain_items();
        repeat (12) @(posedge clk);
        if (otp_pending.size() != 0)
        begin
            note_error($sformatf("%0d results never arrived", otp_pending.size()));
        end
        $display("%0d minutes checked under %0d key writes, stalls on both sides",
                 results_seen, key_writes);
        $display("%0d codes accepted, %0d rejected for a malformed key, %0d errors",
                 match_count, bad_key_count, error_count);
        if (error_count == 0)
        begin
            $display("[decimal_time_otp_generator] OK");
        end
        else
        begin
            $display("[decimal_time_otp_generator] ERROR");
        end
        $finish;
    end

endmodule
